>>> sv/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  localparam int MEM_UNITS = 256;
  localparam int ADDR_W    = $clog2(MEM_UNITS);
  localparam int PTR_W     = ADDR_W + 1;
  localparam int ORDER_W   = 4;
  localparam int OWNER_W   = 8;
  localparam int REQ_W     = 9;
  localparam int SIZE_W    = 9;
  localparam int FRAG_W    = 9;
  localparam int STAT_W    = 2;
  localparam logic [ORDER_W-1:0] MAX_ORDER = ORDER_W'(ADDR_W);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_FREED     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One entry per block start
  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic               free;
    logic [OWNER_W-1:0] owner;
    logic [REQ_W-1:0]   req;
  } blk_entry_t;

  localparam int ENTRY_W = $bits(blk_entry_t);

  // Smallest t with 2^t >= v (v of zero gives zero)
  function automatic logic [ORDER_W-1:0] ceil_log2(logic [REQ_W-1:0] v);
    logic [ORDER_W-1:0] t;
    t = ORDER_W'(REQ_W);
    for (int k = REQ_W; k >= 0; k--) begin
      if (((REQ_W+1)'(1) << k) >= {1'b0, v}) t = ORDER_W'(k);
    end
    return t;
  endfunction

endpackage

>>> sv/bba_req_if.sv
// Request channel: operation, owner and size.
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [bba_pkg::OWNER_W-1:0] owner_id;
  logic [bba_pkg::REQ_W-1:0]   request_size;
  modport source(output valid, operation, owner_id, request_size, input ready);
  modport sink(input valid, operation, owner_id, request_size, output ready);
endinterface

>>> sv/bba_rsp_if.sv
// Result channel: status, block placement and fragmentation total.
interface bba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::STAT_W-1:0] status;
  logic [bba_pkg::ADDR_W-1:0] start_address;
  logic [bba_pkg::SIZE_W-1:0] block_size;
  logic [bba_pkg::FRAG_W-1:0] internal_fragmentation;
  modport source(output valid, status, start_address, block_size,
                 internal_fragmentation, input ready);
  modport sink(input valid, status, start_address, block_size,
               internal_fragmentation, output ready);
endinterface

>>> sv/bba_ram.sv
// Generic single-port-write, registered-read RAM.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/buddy_block_allocator_unit.sv
// Buddy allocator top level. Each request walks the block list in address
// order, with one RAM read (S_RD) and one evaluate (S_EVAL) per block; the
// block-entry RAM has a single read port. One request is worked at a time; a
// finished beat waits in the output register while the next request is taken.
// Writing the order register (saturated to 8) re-creates one free block and
// zeroes the fragmentation total.
module buddy_block_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  bba_req_if.sink                     in_ch,
  bba_rsp_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [bba_pkg::ORDER_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_EVAL = 8'b0000_1000,
    S_SPLT = 8'b0001_0000,
    S_MRD  = 8'b0010_0000,
    S_MEV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ORDER_W-1:0]   mo_r, mo_nxt;
  logic                 op_r, op_nxt;
  logic [OWNER_W-1:0]   owner_r, owner_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [ORDER_W-1:0]   t_r, t_nxt;
  logic [PTR_W-1:0]     idx_r, idx_nxt;
  logic [ORDER_W-1:0]   ord_r, ord_nxt;
  status_t              stat_r, stat_nxt;
  logic [ADDR_W-1:0]    start_r, start_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [FRAG_W-1:0]    frag_r, frag_nxt;
  logic                 ov_r, ov_nxt;
  status_t              ostat_r, ostat_nxt;
  logic [ADDR_W-1:0]    ostart_r, ostart_nxt;
  logic [SIZE_W-1:0]    osize_r, osize_nxt;
  logic [FRAG_W-1:0]    ofrag_r, ofrag_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  blk_entry_t           ram_wdata, rd;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [PTR_W-1:0]     n_units, blk_s, nxt_idx, buddy;
  logic [ORDER_W-1:0]   req_t;

  bba_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_UNITS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd       = blk_entry_t'(ram_rdata);
  assign n_units  = PTR_W'(1) << mo_r;
  assign blk_s    = PTR_W'(1) << rd.order;
  assign nxt_idx  = idx_r + blk_s;
  assign buddy    = idx_r ^ (PTR_W'(1) << ord_r);
  assign req_t    = ceil_log2(in_ch.request_size);

  assign in_ch.ready                = (state_r == S_IDLE);
  assign out_ch.valid               = ov_r;
  assign out_ch.status              = ostat_r;
  assign out_ch.start_address       = ostart_r;
  assign out_ch.block_size          = osize_r;
  assign out_ch.internal_fragmentation = ofrag_r;

  // Sequencer: scan, split, free and merge
  always_comb begin
    state_nxt = state_r;
    mo_nxt    = mo_r;
    op_nxt    = op_r;
    owner_nxt = owner_r;
    req_nxt   = req_r;
    t_nxt     = t_r;
    idx_nxt   = idx_r;
    ord_nxt   = ord_r;
    stat_nxt  = stat_r;
    start_nxt = start_r;
    size_nxt  = size_r;
    frag_nxt  = frag_r;
    ov_nxt    = ov_r;
    ostat_nxt = ostat_r;
    ostart_nxt = ostart_r;
    osize_nxt = osize_r;
    ofrag_nxt = ofrag_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r[ADDR_W-1:0];
    ram_wdata = '0;
    ram_raddr = idx_r[ADDR_W-1:0];

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_INIT: begin
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata.order = mo_r;
        ram_wdata.free  = 1'b1;
        frag_nxt        = '0;
        state_nxt       = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          owner_nxt = in_ch.owner_id;
          req_nxt   = in_ch.request_size;
          t_nxt     = req_t;
          idx_nxt   = '0;
          start_nxt = '0;
          size_nxt  = '0;
          if (in_ch.operation == OP_ALLOC && req_t > mo_r) begin
            stat_nxt  = ST_NO_SPACE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (op_r == OP_ALLOC) begin
          if (rd.free && rd.order >= t_r) begin
            ord_nxt   = rd.order;
            state_nxt = S_SPLT;
          end else if (nxt_idx >= n_units) begin
            stat_nxt  = ST_NO_SPACE;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = nxt_idx;
            state_nxt = S_RD;
          end
        end else begin
          if (!rd.free && rd.owner == owner_r) begin
            ram_we          = 1'b1;
            ram_wdata       = rd;
            ram_wdata.free  = 1'b1;
            ram_wdata.req   = '0;
            if (rd.req != '0) frag_nxt = frag_r - FRAG_W'(blk_s - PTR_W'(rd.req));
            stat_nxt  = ST_FREED;
            start_nxt = idx_r[ADDR_W-1:0];
            size_nxt  = SIZE_W'(blk_s);
            ord_nxt   = rd.order;
            state_nxt = S_MRD;
          end else if (nxt_idx >= n_units) begin
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = nxt_idx;
            state_nxt = S_RD;
          end
        end
      end
      S_SPLT: begin
        ram_we = 1'b1;
        if (ord_r > t_r) begin
          // Hand off the right half as a free block
          ord_nxt         = ord_r - ORDER_W'(1);
          ram_waddr       = ADDR_W'(idx_r + (PTR_W'(1) << (ord_r - ORDER_W'(1))));
          ram_wdata.order = ord_r - ORDER_W'(1);
          ram_wdata.free  = 1'b1;
        end else begin
          ram_wdata.order = t_r;
          ram_wdata.free  = 1'b0;
          ram_wdata.owner = owner_r;
          ram_wdata.req   = req_r;
          if (req_r != '0)
            frag_nxt = frag_r + FRAG_W'((PTR_W'(1) << t_r) - PTR_W'(req_r));
          stat_nxt  = ST_ALLOCATED;
          start_nxt = idx_r[ADDR_W-1:0];
          size_nxt  = SIZE_W'(PTR_W'(1) << t_r);
          state_nxt = S_DONE;
        end
      end
      S_MRD: begin
        ram_raddr = buddy[ADDR_W-1:0];
        state_nxt = (ord_r >= mo_r) ? S_DONE : S_MEV;
      end
      S_MEV: begin
        if (rd.free && rd.order == ord_r) begin
          // Fold the pair into the lower-addressed entry
          ram_we          = 1'b1;
          ram_waddr       = ADDR_W'((buddy < idx_r) ? buddy : idx_r);
          ram_wdata.order = ord_r + ORDER_W'(1);
          ram_wdata.free  = 1'b1;
          idx_nxt   = (buddy < idx_r) ? buddy : idx_r;
          ord_nxt   = ord_r + ORDER_W'(1);
          state_nxt = S_MRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          ostat_nxt  = stat_r;
          ostart_nxt = start_r;
          osize_nxt  = size_r;
          ofrag_nxt  = frag_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Register write rebuilds the store
    if (cfg_we) begin
      mo_nxt    = (cfg_wdata > MAX_ORDER) ? MAX_ORDER : cfg_wdata;
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      mo_r    <= MAX_ORDER;
      frag_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mo_r    <= mo_nxt;
      frag_r  <= frag_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    owner_r  <= owner_nxt;
    req_r    <= req_nxt;
    t_r      <= t_nxt;
    idx_r    <= idx_nxt;
    ord_r    <= ord_nxt;
    stat_r   <= stat_nxt;
    start_r  <= start_nxt;
    size_r   <= size_nxt;
    ostat_r  <= ostat_nxt;
    ostart_r <= ostart_nxt;
    osize_r  <= osize_nxt;
    ofrag_r  <= ofrag_nxt;
  end

  // A new result beat is only loaded from the completion state
  a_beat_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !$past(ov_r)) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside completion");

  // Merges never grow a block past the configured memory
  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEV) |-> (ord_r < mo_r))
    else $error("merge attempted at top order");

  // Splitting never goes below the requested order
  a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLT) |-> (ord_r >= t_r))
    else $error("split below requested order");

endmodule
